FILE: src/rpn_pkg.sv
// Shared types and constants for the reverse Polish stack calculator.
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 4;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 4'd0,
    OP_ADD     = 4'd1,
    OP_MUL     = 4'd2,
    OP_SUB     = 4'd3,
    OP_DIV     = 4'd4,
    OP_REM     = 4'd5,
    OP_POPSHOW = 4'd6,
    OP_SHOWTOP = 4'd7,
    OP_CLEAR   = 4'd8,
    OP_SWAP    = 4'd9,
    OP_DUP     = 4'd10,
    OP_UNKNOWN = 4'd11
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_FEW     = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    WS_NUM = 2'd0,
    WS_A   = 2'd1,
    WS_B   = 2'd2,
    WS_RES = 2'd3
  } wsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    clear_sp;
    logic    pop_b;
    logic    pop_a;
    logic    peek;
    logic    ld_b;
    logic    ld_a;
    logic    push;
    wsel_t   wsel;
    logic    flag_en;
    status_t flag_code;
    logic    show;
    logic    addsub;
    logic    is_sub;
    logic    mul_go;
    logic    mul_fin;
    logic    div_go;
    logic    div_fin;
    logic    is_rem;
    logic    out_load;
  } rpn_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic sp_lt2;
    logic b_zero;
    logic div_busy;
  } rpn_stat_t;

endpackage

FILE: src/rpn_div.sv
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
module rpn_div import rpn_pkg::*; #(
  parameter int NUM_W = DATA_W + FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DATA_W-1:0] denom,
  output logic              busy,
  output logic [NUM_W-1:0]  quot,
  output logic [DATA_W-1:0] rmd
);

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DATA_W-1:0] r_r, r_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // The numerator shifts out of the top of q_r while quotient bits enter at the bottom.
  assign trial = {r_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      q_nxt    = numer;
      r_nxt    = '0;
      d_nxt    = denom;
    end else if (busy_r) begin
      r_nxt   = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rmd  = r_r;

endmodule

FILE: src/rpn_dp.sv
// Datapath: value stack memory, stack pointer, operand registers and arithmetic units.
module rpn_dp import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DATA_W-1:0]   in_number,
  input  rpn_cmd_t            cmd,
  output rpn_stat_t           stat,
  output logic [DATA_W-1:0]   out_value,
  output logic                out_show,
  output logic [STATUS_W-1:0] out_status
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int NUM_W = DATA_W + FRAC_BITS;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] from_mag(input logic neg, input logic [63:0] m);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (m >= 64'(Q_MIN)) ? Q_MIN : (~m[DATA_W-1:0] + 1'b1);
    end else begin
      r = (m > 64'(Q_MAX)) ? Q_MAX : m[DATA_W-1:0];
    end
    return r;
  endfunction

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [SPW-1:0]    sp_m1;
  logic              sp_zero, sp_full;
  logic              pop;
  logic [DATA_W-1:0] rdata_r;
  logic              rd_hit_r;
  logic [DATA_W-1:0] num_r, a_r, b_r, res_r, res_nxt;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] shown_r;
  logic              show_r;
  status_t           status_r, status_nxt;
  logic              flag_req;
  status_t           flag_code;
  logic [DATA_W-1:0] out_value_r;
  logic              out_show_r;
  status_t           out_status_r;

  logic [DATA_W-1:0] mag_a, mag_b;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_sat;
  logic [63:0]       prod_c, prod_r, prod_sh;
  logic [NUM_W-1:0]  div_numer;
  logic [NUM_W-1:0]  div_quot;
  logic [DATA_W-1:0] div_rmd;
  logic              div_busy;

  assign sp_zero = sp_r == '0;
  assign sp_full = sp_r == SPW'(STACK_DEPTH);
  assign sp_m1   = sp_r - 1'b1;
  assign pop     = cmd.pop_a || cmd.pop_b;

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.clear_sp) begin
      sp_nxt = '0;
    end else if (pop && !sp_zero && !cmd.peek) begin
      sp_nxt = sp_m1;
    end else if (cmd.push && !sp_full) begin
      sp_nxt = sp_r + 1'b1;
    end
  end

  // Only the first fault of an item is kept.
  always_comb begin
    flag_req  = 1'b1;
    flag_code = cmd.flag_code;
    priority if (cmd.flag_en) begin
      flag_code = cmd.flag_code;
    end else if (pop && sp_zero) begin
      flag_code = ST_EMPTY;
    end else if (cmd.push && sp_full) begin
      flag_code = ST_FULL;
    end else begin
      flag_req = 1'b0;
    end
  end

  always_comb begin
    status_nxt = status_r;
    if (cmd.start) begin
      status_nxt = ST_OK;
    end else if (flag_req && status_r == ST_OK) begin
      status_nxt = flag_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_comb begin
    unique case (cmd.wsel)
      WS_NUM: wdata = num_r;
      WS_A:   wdata = a_r;
      WS_B:   wdata = b_r;
      WS_RES: wdata = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !sp_full) begin
      mem[sp_r[AW-1:0]] <= wdata;
    end
    if (pop && !sp_zero) begin
      rdata_r <= mem[sp_m1[AW-1:0]];
    end
  end

  assign mag_a = a_r[DATA_W-1] ? (~a_r + 1'b1) : a_r;
  assign mag_b = b_r[DATA_W-1] ? (~b_r + 1'b1) : b_r;

  assign sum = cmd.is_sub ? ({a_r[DATA_W-1], a_r} - {b_r[DATA_W-1], b_r})
                          : ({a_r[DATA_W-1], a_r} + {b_r[DATA_W-1], b_r});
  assign sum_sat = (sum[DATA_W] != sum[DATA_W-1]) ? (sum[DATA_W] ? Q_MIN : Q_MAX)
                                                  : sum[DATA_W-1:0];

  assign prod_c  = 64'(mag_a) * 64'(mag_b);
  assign prod_sh = prod_r >> FRAC_BITS;

  assign div_numer = cmd.is_rem ? NUM_W'(mag_a) : (NUM_W'(mag_a) << FRAC_BITS);

  rpn_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .numer (div_numer),
    .denom (mag_b),
    .busy  (div_busy),
    .quot  (div_quot),
    .rmd   (div_rmd)
  );

  always_comb begin
    res_nxt = res_r;
    priority if (cmd.addsub) begin
      res_nxt = sum_sat;
    end else if (cmd.mul_fin) begin
      res_nxt = from_mag(a_r[DATA_W-1] ^ b_r[DATA_W-1], prod_sh);
    end else if (cmd.div_fin) begin
      res_nxt = cmd.is_rem ? from_mag(a_r[DATA_W-1], 64'(div_rmd))
                           : from_mag(a_r[DATA_W-1] ^ b_r[DATA_W-1], 64'(div_quot));
    end
  end

  always_ff @(posedge clk) begin
    rd_hit_r <= pop && !sp_zero;
    status_r <= status_nxt;
    res_r    <= res_nxt;
    if (cmd.start) begin
      num_r   <= in_number;
      shown_r <= '0;
      show_r  <= 1'b0;
    end else if (cmd.show) begin
      shown_r <= b_r;
      show_r  <= 1'b1;
    end
    if (cmd.ld_b) begin
      b_r <= rd_hit_r ? rdata_r : '0;
    end
    if (cmd.ld_a) begin
      a_r <= rd_hit_r ? rdata_r : '0;
    end
    if (cmd.mul_go) begin
      prod_r <= prod_c;
    end
    if (cmd.out_load) begin
      out_value_r  <= shown_r;
      out_show_r   <= show_r;
      out_status_r <= status_r;
    end
  end

  assign stat.sp_lt2   = sp_r < SPW'(2);
  assign stat.b_zero   = b_r == '0;
  assign stat.div_busy = div_busy;

  assign out_value  = out_value_r;
  assign out_show   = out_show_r;
  assign out_status = out_status_r;

endmodule

FILE: src/rpn_ctrl.sv
// Controller: sequences each token through stack reads, arithmetic and stack writes.
module rpn_ctrl import rpn_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_op,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  rpn_stat_t       stat,
  output rpn_cmd_t        cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_POPB   = 13'b0000000000100,
    S_LDB    = 13'b0000000001000,
    S_CHKB   = 13'b0000000010000,
    S_POPA   = 13'b0000000100000,
    S_LDA    = 13'b0000001000000,
    S_EXEC   = 13'b0000010000000,
    S_MULW   = 13'b0000100000000,
    S_DIVW   = 13'b0001000000000,
    S_WR1    = 13'b0010000000000,
    S_WR2    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   two_writes;

  assign two_writes = (op_r == OP_DUP) || (op_r == OP_SWAP);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.is_sub    = op_r == OP_SUB;
    cmd.is_rem    = op_r == OP_REM;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          op_nxt    = op_t'(in_op);
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_r)
          OP_PUSH: state_nxt = S_WR1;
          OP_CLEAR: begin
            cmd.clear_sp = 1'b1;
            state_nxt    = S_FIN;
          end
          OP_SWAP: begin
            if (stat.sp_lt2) begin
              cmd.flag_en   = 1'b1;
              cmd.flag_code = ST_FEW;
              state_nxt     = S_FIN;
            end else begin
              state_nxt = S_POPB;
            end
          end
          OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_REM, OP_POPSHOW, OP_SHOWTOP, OP_DUP: begin
            state_nxt = S_POPB;
          end
          default: begin
            cmd.flag_en   = 1'b1;
            cmd.flag_code = ST_UNKNOWN;
            state_nxt     = S_FIN;
          end
        endcase
      end
      S_POPB: begin
        cmd.pop_b = 1'b1;
        cmd.peek  = op_r == OP_SHOWTOP;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_CHKB;
      end
      S_CHKB: begin
        priority if (op_r == OP_POPSHOW || op_r == OP_SHOWTOP) begin
          cmd.show  = 1'b1;
          state_nxt = S_FIN;
        end else if ((op_r == OP_DIV || op_r == OP_REM) && stat.b_zero) begin
          // The divisor is gone; the left operand stays where it is.
          cmd.flag_en   = 1'b1;
          cmd.flag_code = ST_DIVZERO;
          state_nxt     = S_FIN;
        end else if (op_r == OP_DUP) begin
          state_nxt = S_WR1;
        end else begin
          state_nxt = S_POPA;
        end
      end
      S_POPA: begin
        cmd.pop_a = 1'b1;
        state_nxt = S_LDA;
      end
      S_LDA: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (op_r == OP_MUL) begin
          cmd.mul_go = 1'b1;
          state_nxt  = S_MULW;
        end else if (op_r == OP_DIV || op_r == OP_REM) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIVW;
        end else if (op_r == OP_SWAP) begin
          state_nxt = S_WR1;
        end else begin
          cmd.addsub = 1'b1;
          state_nxt  = S_WR1;
        end
      end
      S_MULW: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_WR1;
      end
      S_DIVW: begin
        if (!stat.div_busy) begin
          cmd.div_fin = 1'b1;
          state_nxt   = S_WR1;
        end
      end
      S_WR1: begin
        cmd.push = 1'b1;
        priority if (op_r == OP_PUSH) begin
          cmd.wsel = WS_NUM;
        end else if (two_writes) begin
          cmd.wsel = WS_B;
        end else begin
          cmd.wsel = WS_RES;
        end
        state_nxt = two_writes ? S_WR2 : S_FIN;
      end
      S_WR2: begin
        // Swap pushes the old top first, then the old second entry above it.
        cmd.push  = 1'b1;
        cmd.wsel  = (op_r == OP_SWAP) ? WS_A : WS_B;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PUSH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

FILE: src/rpn_stack_calculator_top.sv
// Reverse Polish calculator: one token in, one result beat out per token.
// Divide and remainder tokens wait on the bit-serial divider.
// One token is worked on at a time; the next is taken while the last result still waits.
// Synchronous active-low reset empties the stack and drops any pending result beat.
// Stack entries are undefined after reset until pushed.
module rpn_stack_calculator_top import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] number
  input  logic [OP_W-1:0]   in_tuser,   // [3:0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] shown_value
  output logic [3:0]        out_tuser   // [0] show_valid, [3:1] status
);

  rpn_cmd_t            cmd;
  rpn_stat_t           stat;
  logic [DATA_W-1:0]   out_value;
  logic                out_show;
  logic [STATUS_W-1:0] out_status;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_number  (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_value  (out_value),
    .out_show   (out_show),
    .out_status (out_status)
  );

  assign out_tdata = out_value;
  assign out_tuser = {out_status, out_show};

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("token accepted while another is in progress");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while a beat waits");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("value present on a beat that shows nothing");

  a_show_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tuser[3:1] == ST_OK || out_tuser[3:1] == ST_EMPTY))
    else $error("shown value with an impossible status");

endmodule

FILE: tb/rpn_stack_calculator_top_test.sv
// Self-checking testbench for the reverse Polish calculator: tokens in, result beats checked.
`timescale 1ns / 1ps

module rpn_stack_calculator_top_test;
  import rpn_pkg::*;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic [OP_W-1:0] OP_LAST_CODE = '1;
  localparam int TOKEN_TARGET = 1350;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] number;
    bit                sync;
    bit                calm;
  } token_t;

  typedef struct {
    logic signed [DATA_W-1:0] shown;
    logic                     valid;
    status_t                  status;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0]   in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [3:0]        out_tuser;

  rpn_stack_calculator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  token_t  pending_tokens[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      in_taken = 1'b0;
  bit      quiet = 1'b0;
  int      in_gap = 0;
  int      rdy_gap = 0;

  // Calculator state as the block should hold it.
  logic signed [DATA_W-1:0] calc_stack [STACK_DEPTH_DEF];
  int      calc_depth = 0;
  status_t calc_fault;

  function automatic void raise(status_t code);
    if (calc_fault == ST_OK) calc_fault = code;
  endfunction

  function automatic logic signed [DATA_W-1:0] stack_pop();
    if (calc_depth > 0) begin
      calc_depth--;
      return calc_stack[calc_depth];
    end
    raise(ST_EMPTY);
    return '0;
  endfunction

  function automatic void stack_push(logic signed [DATA_W-1:0] v);
    if (calc_depth < STACK_DEPTH_DEF) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      raise(ST_FULL);
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [DATA_W-1:0] v);
    longint x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [DATA_W-1:0] from_magnitude(bit neg, logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? Q_MIN : -m[DATA_W-1:0];
    return (m > 64'h7FFF_FFFF) ? Q_MAX : m[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] q_mul(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b);
    return from_magnitude((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >> FRAC_BITS_DEF);
  endfunction

  function automatic logic signed [DATA_W-1:0] q_div(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b);
    return from_magnitude((a < 0) != (b < 0), (magnitude(a) << FRAC_BITS_DEF) / magnitude(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] q_rem(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b);
    return from_magnitude(a < 0, magnitude(a) % magnitude(b));
  endfunction

  // Applies one token to the calculator state and returns the beat it must produce.
  function automatic answer_t calc_token(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] num);
    answer_t r;
    logic signed [DATA_W-1:0] a, b;
    r.shown = '0;
    r.valid = 1'b0;
    calc_fault = ST_OK;
    case (code)
      OP_PUSH: stack_push(num);
      OP_ADD, OP_SUB, OP_MUL: begin
        b = stack_pop();
        a = stack_pop();
        if (code == OP_ADD) stack_push(clamp(longint'(a) + longint'(b)));
        else if (code == OP_SUB) stack_push(clamp(longint'(a) - longint'(b)));
        else stack_push(q_mul(a, b));
      end
      OP_DIV, OP_REM: begin
        // A zero divisor is consumed but the left operand is left in place.
        b = stack_pop();
        if (b == 0) begin
          raise(ST_DIVZERO);
        end else begin
          a = stack_pop();
          stack_push(code == OP_DIV ? q_div(a, b) : q_rem(a, b));
        end
      end
      OP_POPSHOW: begin
        r.shown = stack_pop();
        r.valid = 1'b1;
      end
      OP_SHOWTOP: begin
        r.valid = 1'b1;
        if (calc_depth > 0) r.shown = calc_stack[calc_depth-1];
        else raise(ST_EMPTY);
      end
      OP_CLEAR: calc_depth = 0;
      OP_SWAP: begin
        if (calc_depth > 1) begin
          a = calc_stack[calc_depth-1];
          calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
          calc_stack[calc_depth-2] = a;
        end else begin
          raise(ST_FEW);
        end
      end
      OP_DUP: begin
        a = stack_pop();
        stack_push(a);
        stack_push(a);
      end
      default: raise(ST_UNKNOWN);
    endcase
    r.status = calc_fault;
    return r;
  endfunction

  // Stimulus generation, with a rough idea of the stack depth to steer the sequences.
  int gen_depth = 0;
  bit next_sync = 1'b0;

  task automatic add_token(logic [OP_W-1:0] code, logic [DATA_W-1:0] num);
    pending_tokens.push_back('{code, num, next_sync,
                               pending_tokens.size() >= TOKEN_TARGET - QUIET_TAIL});
    next_sync = 1'b0;
    case (code)
      OP_PUSH: if (gen_depth < STACK_DEPTH_DEF) gen_depth++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
      OP_POPSHOW: if (gen_depth > 0) gen_depth--;
      OP_CLEAR: gen_depth = 0;
      OP_DUP: gen_depth = (gen_depth == 0) ? 2 :
                          (gen_depth < STACK_DEPTH_DEF) ? gen_depth + 1 : gen_depth;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      4, 5: return $urandom;
      6: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ONE;
          3: return -Q_ONE;
          4: return 32'h0000_0001;
          default: return '1;
        endcase
      end
      7: return '0;
      default: return DATA_W'((int'($urandom_range(0, 600)) - 300) * (1 << FRAC_BITS_DEF));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_command();
    case ($urandom_range(0, 9))
      0: return OP_ADD;
      1: return OP_MUL;
      2: return OP_SUB;
      3: return OP_DIV;
      4: return OP_REM;
      5: return OP_SWAP;
      6: return OP_DUP;
      7: return OP_POPSHOW;
      8: return OP_SHOWTOP;
      default: return OP_ADD;
    endcase
  endfunction

  task automatic gen_expression();
    int steps;
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      if (gen_depth < 2 || (gen_depth < 40 && $urandom_range(0, 2) == 0))
        add_token(OP_PUSH, rand_value());
      else
        add_token(pick_command(), $urandom);
    end
  endtask

  // Fills the stack to the brim, then pushes against it.
  task automatic gen_fill();
    add_token(OP_CLEAR, $urandom);
    repeat (STACK_DEPTH_DEF) add_token(OP_PUSH, rand_value());
    add_token(OP_PUSH, rand_value());
    add_token(OP_PUSH, rand_value());
    add_token(OP_DUP, $urandom);
    add_token(OP_SHOWTOP, $urandom);
    add_token(OP_SWAP, $urandom);
    add_token(OP_MUL, $urandom);
    add_token(OP_POPSHOW, $urandom);
  endtask

  // Input driver: a new beat is put up at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_tokens.size() != 0 &&
                   !(pending_tokens[0].sync && expected_answers.size() != 0)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_tokens[0].op;
        in_tdata  <= pending_tokens[0].number;
        quiet = pending_tokens[0].calm;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        void'(pending_tokens.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (rdy_gap > 0) begin
      rdy_gap--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rdy_gap = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Prediction on each accepted token, checking on each accepted result, and the watchdog.
  always @(posedge clk) begin
    answer_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      expected_answers.push_back(calc_token(in_tuser, in_tdata));
      in_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      if (expected_answers.size() == 0) begin
        $error("result beat with no token waiting: shown_value %h, tuser %h",
               out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (out_tdata !== want.shown) begin
          $error("shown_value: expected %h, actual %h", want.shown, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.valid) begin
          $error("show_valid: expected %b, actual %b", want.valid, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[3:1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser[3:1]);
          mismatches++;
        end
      end
    end
    if (!rst_n || moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Directed opening: empty-stack faults, unknown codes, saturation, zero divisor,
    // most negative quotient and remainder by the all-ones word (minus one LSB).
    add_token(OP_POPSHOW, '0);
    add_token(OP_SHOWTOP, '0);
    add_token(OP_SWAP, '0);
    add_token(OP_DUP, '0);
    add_token(OP_ADD, '0);
    add_token(OP_UNKNOWN, '1);
    add_token(OP_LAST_CODE, '0);
    add_token(OP_PUSH, Q_MAX);
    add_token(OP_PUSH, Q_MAX);
    add_token(OP_ADD, '0);
    add_token(OP_PUSH, Q_MIN);
    add_token(OP_SUB, '0);
    add_token(OP_PUSH, Q_ONE + (Q_ONE >>> 1));
    add_token(OP_MUL, '0);
    add_token(OP_PUSH, '0);
    add_token(OP_DIV, '0);
    add_token(OP_PUSH, -Q_ONE);
    add_token(OP_SWAP, '0);
    add_token(OP_REM, '0);
    add_token(OP_CLEAR, '0);
    add_token(OP_PUSH, Q_MIN);
    add_token(OP_PUSH, '1);
    add_token(OP_DIV, '0);
    add_token(OP_PUSH, Q_MIN);
    add_token(OP_PUSH, '1);
    add_token(OP_REM, '0);
    add_token(OP_POPSHOW, '0);
    add_token(OP_SHOWTOP, '0);
    add_token(OP_CLEAR, '0);
    add_token(OP_DIV, '0);

    // The random part starts only once the directed results are all back.
    next_sync = 1'b1;
    gen_fill();
    while (pending_tokens.size() < TOKEN_TARGET) begin
      case ($urandom_range(0, 59))
        0: gen_fill();
        1, 2, 3, 4: repeat ($urandom_range(1, 4)) add_token(OP_W'($urandom), $urandom);
        5: add_token(OP_CLEAR, $urandom);
        default: gen_expression();
      endcase
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    @(negedge clk);
    while (pending_tokens.size() != 0 || in_tvalid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
src/rpn_pkg.sv
src/rpn_div.sv
src/rpn_dp.sv
src/rpn_ctrl.sv
src/rpn_stack_calculator_top.sv
tb/rpn_stack_calculator_top_test.sv
